/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk while rst_n is high.
`define ASSERT_CLKD(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLKD(name, clk, rst_n, (ante) |=> (cons), msg)

`endif

/* hdl/fcpb_pkg.sv */
// ---------------------------------------------------------------------------
// fcpb_pkg
// Types, constants and helpers shared by the sparsity pattern builder.
// ---------------------------------------------------------------------------
package fcpb_pkg;

  // Parameter defaults for the top level.
  localparam int MAX_NODES_DEF         = 256;
  localparam int MAX_FREE_NODES_DEF    = 64;
  localparam int NODES_PER_ELEMENT_DEF = 8;

  // Fixed field widths.
  localparam int NODE_W      = 8;   // node number on the request port
  localparam int FI_W        = 7;   // free-node index
  localparam int CNT_W       = 8;   // dof_count, drain column and drain row
  localparam int WORD_W      = 16;  // output index and value
  localparam int COL_W       = 9;   // a DOF derived from any 7-bit free index
  localparam int MAX_CORNERS = 8;   // corner ports on the request channel
  localparam int DOFS_PER_NODE = 3;

  // Row scan works on one chunk of the column word per cycle while it steps.
  localparam int CHUNK    = 16;
  localparam int CHUNK_LG = 4;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_ELEM  = 2'd1,
    REQ_DRAIN = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    PH_PTR  = 2'd0,
    PH_ROW  = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  localparam logic KIND_PTR = 1'b0;
  localparam logic KIND_ROW = 1'b1;

  // Outcome of one chunk of the row scan.
  typedef struct packed {
    logic             hit;   // a stored row was found in this chunk
    logic             done;  // no later chunk holds a row below the limit
    logic [CNT_W-1:0] row;   // lowest row found
  } scan_res_t;

  // Zero-based DOF d of a free node; only meaningful for a nonzero index.
  function automatic logic [COL_W-1:0] dof_col(input logic [FI_W-1:0] fi,
                                               input logic [1:0]      d);
    return COL_W'(fi) * COL_W'(DOFS_PER_NODE) + COL_W'(d) - COL_W'(DOFS_PER_NODE);
  endfunction

endpackage

/* hdl/fcpb_ram.sv */
// ---------------------------------------------------------------------------
// fcpb_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module fcpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/fcpb_row_scan.sv */
// ---------------------------------------------------------------------------
// fcpb_row_scan
// Finds the next stored row of one bitmap column, one chunk per cycle while step_i is high.
// ---------------------------------------------------------------------------
module fcpb_row_scan #(
  parameter int DOF_MAX = 3 * fcpb_pkg::MAX_FREE_NODES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [DOF_MAX-1:0]         word_i,
  input  logic                       start_i,
  input  logic                       step_i,
  input  logic [fcpb_pkg::CNT_W-1:0] first_row_i,
  input  logic [fcpb_pkg::CNT_W-1:0] row_limit_i,
  output fcpb_pkg::scan_res_t        res_o
);

  localparam int NCHUNK = (DOF_MAX + fcpb_pkg::CHUNK - 1) / fcpb_pkg::CHUNK;
  localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W  = (1 << CH_W) * fcpb_pkg::CHUNK;
  localparam int RW     = (($clog2(PAD_W) > fcpb_pkg::CNT_W) ? $clog2(PAD_W)
                                                             : fcpb_pkg::CNT_W) + 1;

  logic [CH_W-1:0]            chunk_q, chunk_d;
  logic [PAD_W-1:0]           word_pad;
  logic [fcpb_pkg::CHUNK-1:0] bits;
  logic [RW-1:0]              base;

  always_comb begin
    chunk_d = chunk_q;
    if (start_i) begin
      chunk_d = CH_W'(first_row_i >> fcpb_pkg::CHUNK_LG);
    end else if (step_i) begin
      chunk_d = chunk_q + CH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
    end else begin
      chunk_q <= chunk_d;
    end
  end

  assign word_pad = PAD_W'(word_i);
  assign bits     = word_pad[chunk_q * fcpb_pkg::CHUNK +: fcpb_pkg::CHUNK];
  assign base     = RW'(chunk_q) << fcpb_pkg::CHUNK_LG;

  // Lowest qualifying row wins: the loop runs downward so it writes last.
  always_comb begin
    logic [RW-1:0] row;
    res_o = '0;
    for (int b = fcpb_pkg::CHUNK - 1; b >= 0; b--) begin
      row = base + RW'(b);
      if (bits[b] && (row >= RW'(first_row_i)) && (row < RW'(row_limit_i))) begin
        res_o.hit = 1'b1;
        res_o.row = fcpb_pkg::CNT_W'(row);
      end
    end
    res_o.done = (base + RW'(fcpb_pkg::CHUNK)) >= RW'(row_limit_i);
  end

endmodule

/* hdl/fem_csc_pattern_builder_top.sv */
// Load requests finish in the cycle they are taken. Element requests take one node-map read
// per corner and one bitmap read-modify-write per corner DOF. Drain requests scan the
// column word in 16-row chunks and can wait on output stall. Output is registered.
// Reset clears all control state, then a clearing pass over every address of both
// memories zeroes them before any request is taken.
// ---------------------------------------------------------------------------
// fem_csc_pattern_builder_top
// Symbolic finite-element assembly: builds and streams the compressed-sparse-
// column nonzero pattern of the stiffness matrix from a DOF-by-DOF bitmap.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fem_csc_pattern_builder_top #(
  parameter int MAX_NODES         = fcpb_pkg::MAX_NODES_DEF,
  parameter int MAX_FREE_NODES    = fcpb_pkg::MAX_FREE_NODES_DEF,
  parameter int NODES_PER_ELEMENT = fcpb_pkg::NODES_PER_ELEMENT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration: dof_count
  input  logic                        cfg_we_i,
  input  logic [fcpb_pkg::CNT_W-1:0]  cfg_wdata_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [fcpb_pkg::NODE_W-1:0] node_id_i,
  input  logic [fcpb_pkg::FI_W-1:0]   free_index_i,
  input  logic [fcpb_pkg::NODE_W-1:0] corner_a_i,
  input  logic [fcpb_pkg::NODE_W-1:0] corner_b_i,
  input  logic [fcpb_pkg::NODE_W-1:0] corner_c_i,
  input  logic [fcpb_pkg::NODE_W-1:0] corner_d_i,
  input  logic [fcpb_pkg::NODE_W-1:0] corner_e_i,
  input  logic [fcpb_pkg::NODE_W-1:0] corner_f_i,
  input  logic [fcpb_pkg::NODE_W-1:0] corner_g_i,
  input  logic [fcpb_pkg::NODE_W-1:0] corner_h_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        word_kind_o,
  output logic [fcpb_pkg::WORD_W-1:0] word_index_o,
  output logic [fcpb_pkg::WORD_W-1:0] word_value_o,
  output logic                        last_word_o
);

  // Bitmap geometry: one memory row per column, one bit per row of the matrix.
  localparam int DOF_MAX    = fcpb_pkg::DOFS_PER_NODE * MAX_FREE_NODES;
  localparam int NODE_SPAN  = 1 << fcpb_pkg::NODE_W;
  // Node numbers on the port never exceed the 8-bit range, so the node map
  // needs no more entries than that.
  localparam int NODE_DEPTH = (MAX_NODES < NODE_SPAN) ? MAX_NODES : NODE_SPAN;
  localparam int NA_W       = $clog2(NODE_DEPTH);
  localparam int BA_W       = $clog2(DOF_MAX);
  localparam int CLR_LEN    = (NODE_DEPTH > DOF_MAX) ? NODE_DEPTH : DOF_MAX;
  localparam int CLR_W      = $clog2(CLR_LEN);
  localparam int K_W        = $clog2(NODES_PER_ELEMENT);

  typedef logic [DOF_MAX-1:0] bm_word_t;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LOOKUP = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_SCAN   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [fcpb_pkg::CNT_W-1:0] dof_count_q;
  logic [fcpb_pkg::CNT_W-1:0] cnt;
  logic                       in_accept;

  // Clearing pass.
  logic [CLR_W-1:0] clr_q, clr_d;

  // Element request: corners, their free indices and the shared row mask.
  logic [fcpb_pkg::NODE_W-1:0] corner_in [fcpb_pkg::MAX_CORNERS];
  logic [fcpb_pkg::NODE_W-1:0] corner_q  [NODES_PER_ELEMENT];
  logic [fcpb_pkg::FI_W-1:0]   fi_q      [NODES_PER_ELEMENT];
  bm_word_t                    mask_q;
  bm_word_t                    cap_mask;
  logic [fcpb_pkg::FI_W-1:0]   cap_fi;

  // Lookup sequencer and its capture stage.
  logic [K_W-1:0]              look_k_q, look_k_d;
  logic                        look_busy_q, look_busy_d;
  logic [fcpb_pkg::NODE_W-1:0] look_node;
  logic                        look_ok;
  logic                        cap_vld_q, cap_vld_d;
  logic [K_W-1:0]              cap_k_q;
  logic                        cap_ok_q;

  // Update sequencer: issue read, then write back in the next cycle.
  logic [K_W-1:0]             upd_k_q, upd_k_d;
  logic [1:0]                 upd_d_q, upd_d_d;
  logic                       upd_busy_q, upd_busy_d;
  logic [fcpb_pkg::FI_W-1:0]  upd_fi;
  logic [fcpb_pkg::COL_W-1:0] upd_col;
  logic                       upd_ok;
  logic                       wr_vld_q;
  logic [BA_W-1:0]            wr_addr_q;

  // Drain state.
  fcpb_pkg::phase_e           phase_q, phase_d;
  logic [fcpb_pkg::CNT_W-1:0] drain_col_q, drain_col_d;
  logic [fcpb_pkg::CNT_W-1:0] drain_row_q, drain_row_d;
  logic [fcpb_pkg::WORD_W-1:0] nnz_q, nnz_d;
  logic [fcpb_pkg::CNT_W-1:0] ptr_col;
  logic                       scan_ok;
  logic                       scan_start;
  logic                       scan_step;
  fcpb_pkg::scan_res_t        scan_res;

  // Result of the scan state.
  logic                        res_vld;
  logic                        res_kind;
  logic [fcpb_pkg::WORD_W-1:0] res_index;
  logic [fcpb_pkg::WORD_W-1:0] res_value;
  logic                        res_last;
  logic                        out_free;
  logic                        commit;

  // Output register.
  logic                        out_valid_q;
  logic                        out_kind_q;
  logic [fcpb_pkg::WORD_W-1:0] out_index_q;
  logic [fcpb_pkg::WORD_W-1:0] out_value_q;
  logic                        out_last_q;

  // Memory ports.
  logic                      nm_we, nm_re;
  logic [NA_W-1:0]           nm_waddr, nm_raddr;
  logic [fcpb_pkg::FI_W-1:0] nm_wdata, nm_rdata;
  logic                      bm_we, bm_re;
  logic [BA_W-1:0]           bm_waddr, bm_raddr;
  bm_word_t                  bm_wdata, bm_rdata;

  // -------------------------------------------------------------------------
  // Handshake and configuration
  // -------------------------------------------------------------------------
  // A request is taken only in the idle state. Load requests finish in the
  // cycle they are taken; element and drain requests hold the channel until
  // their memory work is complete, so no two requests touch the memories at
  // the same time.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Columns and rows beyond the bitmap are never drained.
  assign cnt = (32'(dof_count_q) > DOF_MAX) ? fcpb_pkg::CNT_W'(DOF_MAX) : dof_count_q;

  assign corner_in[0] = corner_a_i;
  assign corner_in[1] = corner_b_i;
  assign corner_in[2] = corner_c_i;
  assign corner_in[3] = corner_d_i;
  assign corner_in[4] = corner_e_i;
  assign corner_in[5] = corner_f_i;
  assign corner_in[6] = corner_g_i;
  assign corner_in[7] = corner_h_i;

  // -------------------------------------------------------------------------
  // Node map: written by the clearing pass and by load requests, read once
  // per corner during the lookup phase of an element request.
  // -------------------------------------------------------------------------
  always_comb begin
    nm_we    = 1'b0;
    nm_waddr = '0;
    nm_wdata = '0;
    if (state_q == ST_CLEAR) begin
      nm_we    = (32'(clr_q) < NODE_DEPTH);
      nm_waddr = NA_W'(clr_q);
    end else if (in_accept && (req_type_i == fcpb_pkg::REQ_LOAD) &&
                 (32'(node_id_i) < MAX_NODES)) begin
      nm_we    = 1'b1;
      nm_waddr = NA_W'(node_id_i);
      nm_wdata = free_index_i;
    end
  end

  // A corner of zero is absent and one beyond the node range counts as fixed.
  assign look_node = corner_q[look_k_q];
  assign look_ok   = (look_node != '0) && (32'(look_node) < MAX_NODES);
  assign nm_re     = (state_q == ST_LOOKUP) && look_busy_q;
  assign nm_raddr  = NA_W'(look_node);
  assign cap_vld_d = nm_re;

  // The captured free index yields up to three DOFs; each one inside the
  // bitmap becomes a row of the mask that every column of this element gets.
  assign cap_fi = cap_ok_q ? nm_rdata : '0;

  always_comb begin
    logic [fcpb_pkg::COL_W-1:0] col;
    cap_mask = '0;
    for (int d = 0; d < fcpb_pkg::DOFS_PER_NODE; d++) begin
      col = fcpb_pkg::dof_col(cap_fi, 2'(d));
      if ((cap_fi != '0) && (32'(col) < DOF_MAX)) begin
        cap_mask = cap_mask | (bm_word_t'(1) << col);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Bitmap: each column of the element is read, OR-ed with the mask and
  // written back in the next cycle. Reads and writes of consecutive columns
  // overlap. If a column repeats (a node named twice, or two nodes sharing a
  // free index) the second read may miss the first write, but both write the
  // same old contents OR the same mask, so the stored result is unchanged.
  // -------------------------------------------------------------------------
  assign upd_fi  = fi_q[upd_k_q];
  assign upd_col = fcpb_pkg::dof_col(upd_fi, upd_d_q);
  assign upd_ok  = (state_q == ST_UPDATE) && upd_busy_q && (upd_fi != '0) &&
                   (32'(upd_col) < DOF_MAX);

  always_comb begin
    bm_re    = 1'b0;
    bm_raddr = '0;
    if (upd_ok) begin
      bm_re    = 1'b1;
      bm_raddr = BA_W'(upd_col);
    end else if (scan_start && (drain_col_q < cnt)) begin
      // A drain request reads the current column at the accepting edge.
      bm_re    = 1'b1;
      bm_raddr = BA_W'(drain_col_q);
    end
  end

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = '0;
    bm_wdata = '0;
    if (state_q == ST_CLEAR) begin
      bm_we    = (32'(clr_q) < DOF_MAX);
      bm_waddr = BA_W'(clr_q);
    end else if (wr_vld_q) begin
      bm_we    = 1'b1;
      bm_waddr = wr_addr_q;
      bm_wdata = bm_rdata | mask_q;
    end
  end

  fcpb_ram #(
    .WIDTH (fcpb_pkg::FI_W),
    .DEPTH (NODE_DEPTH)
  ) u_node_map (
    .clk_i   (clk_i),
    .we_i    (nm_we),
    .waddr_i (nm_waddr),
    .wdata_i (nm_wdata),
    .re_i    (nm_re),
    .raddr_i (nm_raddr),
    .rdata_o (nm_rdata)
  );

  fcpb_ram #(
    .WIDTH (DOF_MAX),
    .DEPTH (DOF_MAX)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (bm_we),
    .waddr_i (bm_waddr),
    .wdata_i (bm_wdata),
    .re_i    (bm_re),
    .raddr_i (bm_raddr),
    .rdata_o (bm_rdata)
  );

  // -------------------------------------------------------------------------
  // Drain: the scan unit walks the column word read at acceptance in chunks
  // of sixteen rows, starting at the chunk that holds the saved drain row.
  // -------------------------------------------------------------------------
  assign scan_start = in_accept && (req_type_i == fcpb_pkg::REQ_DRAIN) &&
                      (phase_q == fcpb_pkg::PH_ROW);
  assign scan_ok    = (drain_col_q < cnt) && (drain_row_q < cnt);

  fcpb_row_scan #(
    .DOF_MAX (DOF_MAX)
  ) u_row_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (bm_rdata),
    .start_i     (scan_start),
    .step_i      (scan_step),
    .first_row_i (drain_row_q),
    .row_limit_i (cnt),
    .res_o       (scan_res)
  );

  // Decide what the drain request in the scan state returns. In the pointer
  // phase the current column's pointer goes out directly. In the row phase a
  // found row goes out; when the column holds no further row the column
  // advances and its pointer goes out instead. The pointer of a column at or
  // past the drained size is the last word.
  always_comb begin
    res_vld     = 1'b0;
    res_kind    = fcpb_pkg::KIND_PTR;
    res_index   = '0;
    res_value   = '0;
    res_last    = 1'b0;
    scan_step   = 1'b0;
    ptr_col     = drain_col_q;
    phase_d     = phase_q;
    drain_col_d = drain_col_q;
    drain_row_d = drain_row_q;
    nnz_d       = nnz_q;
    if (state_q == ST_SCAN) begin
      if ((phase_q == fcpb_pkg::PH_ROW) && scan_ok && scan_res.hit) begin
        res_vld     = 1'b1;
        res_kind    = fcpb_pkg::KIND_ROW;
        res_index   = nnz_q;
        res_value   = fcpb_pkg::WORD_W'(scan_res.row);
        nnz_d       = nnz_q + fcpb_pkg::WORD_W'(1);
        drain_row_d = scan_res.row + fcpb_pkg::CNT_W'(1);
      end else if ((phase_q == fcpb_pkg::PH_PTR) || !scan_ok || scan_res.done) begin
        if ((phase_q == fcpb_pkg::PH_ROW) && (drain_col_q < cnt)) begin
          ptr_col = drain_col_q + fcpb_pkg::CNT_W'(1);
        end
        res_vld     = 1'b1;
        res_kind    = fcpb_pkg::KIND_PTR;
        res_index   = fcpb_pkg::WORD_W'(ptr_col);
        res_value   = nnz_q;
        res_last    = !(ptr_col < cnt);
        drain_col_d = ptr_col;
        drain_row_d = (ptr_col < cnt) ? '0 : drain_row_q;
        phase_d     = (ptr_col < cnt) ? fcpb_pkg::PH_ROW : fcpb_pkg::PH_DONE;
      end else begin
        scan_step = 1'b1;
      end
    end
  end

  // The result waits in the scan state until the output register is free.
  assign out_free = !out_valid_q || !out_stall_i;
  assign commit   = res_vld && out_free;

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    look_k_d    = look_k_q;
    look_busy_d = look_busy_q;
    upd_k_d     = upd_k_q;
    upd_d_d     = upd_d_q;
    upd_busy_d  = upd_busy_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + CLR_W'(1);
        if (clr_q == CLR_W'(CLR_LEN - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (fcpb_pkg::req_e'(req_type_i))
            fcpb_pkg::REQ_ELEM: begin
              state_d     = ST_LOOKUP;
              look_k_d    = '0;
              look_busy_d = 1'b1;
            end
            fcpb_pkg::REQ_DRAIN: begin
              // Once the last word is out, drain requests give nothing.
              if (phase_q != fcpb_pkg::PH_DONE) begin
                state_d = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        if (look_busy_q) begin
          if (look_k_q == K_W'(NODES_PER_ELEMENT - 1)) begin
            look_busy_d = 1'b0;
          end else begin
            look_k_d = look_k_q + K_W'(1);
          end
        end else begin
          // The last corner is captured in this cycle.
          state_d    = ST_UPDATE;
          upd_k_d    = '0;
          upd_d_d    = '0;
          upd_busy_d = 1'b1;
        end
      end
      ST_UPDATE: begin
        if (upd_busy_q) begin
          if (upd_d_q == 2'(fcpb_pkg::DOFS_PER_NODE - 1)) begin
            upd_d_d = '0;
            if (upd_k_q == K_W'(NODES_PER_ELEMENT - 1)) begin
              upd_busy_d = 1'b0;
            end else begin
              upd_k_d = upd_k_q + K_W'(1);
            end
          end else begin
            upd_d_d = upd_d_q + 2'(1);
          end
        end else begin
          // The final write-back happens in this cycle.
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      dof_count_q <= '0;
      look_k_q    <= '0;
      look_busy_q <= 1'b0;
      cap_vld_q   <= 1'b0;
      upd_k_q     <= '0;
      upd_d_q     <= '0;
      upd_busy_q  <= 1'b0;
      wr_vld_q    <= 1'b0;
      phase_q     <= fcpb_pkg::PH_PTR;
      drain_col_q <= '0;
      drain_row_q <= '0;
      nnz_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      if (cfg_we_i) begin
        dof_count_q <= cfg_wdata_i;
      end
      look_k_q    <= look_k_d;
      look_busy_q <= look_busy_d;
      cap_vld_q   <= cap_vld_d;
      upd_k_q     <= upd_k_d;
      upd_d_q     <= upd_d_d;
      upd_busy_q  <= upd_busy_d;
      wr_vld_q    <= upd_ok;
      if (commit) begin
        phase_q     <= phase_d;
        drain_col_q <= drain_col_d;
        drain_row_q <= drain_row_d;
        nnz_q       <= nnz_d;
      end
      out_valid_q <= commit || (out_valid_q && out_stall_i);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept && (req_type_i == fcpb_pkg::REQ_ELEM)) begin
      for (int k = 0; k < NODES_PER_ELEMENT; k++) begin
        corner_q[k] <= corner_in[k];
      end
      mask_q <= '0;
    end else if (cap_vld_q) begin
      mask_q <= mask_q | cap_mask;
    end
    if (cap_vld_q) begin
      fi_q[cap_k_q] <= cap_fi;
    end
    cap_k_q   <= look_k_q;
    cap_ok_q  <= look_ok;
    wr_addr_q <= BA_W'(upd_col);
    if (commit) begin
      out_kind_q  <= res_kind;
      out_index_q <= res_index;
      out_value_q <= res_value;
      out_last_q  <= res_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign word_kind_o  = out_kind_q;
  assign word_index_o = out_index_q;
  assign word_value_o = out_value_q;
  assign last_word_o  = out_last_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  // The bitmap is only written by the clearing pass and the element update.
  `ASSERT_CLKD(a_bm_write_owner, clk_i, rst_ni, bm_we |-> ((state_q == ST_CLEAR) || (state_q == ST_UPDATE)), "bitmap written outside clear or update")
  // Every element access has retired before the next request can be taken.
  `ASSERT_CLKD(a_idle_drained, clk_i, rst_ni, (state_q == ST_IDLE) |-> (!wr_vld_q && !cap_vld_q), "element access pending in idle")
  // The final pointer word ends the drain for good.
  `ASSERT_NEXT(a_last_word_done, clk_i, rst_ni, commit && res_last, phase_q == fcpb_pkg::PH_DONE, "drain not finished after last word")
  `ASSERT_NEXT(a_done_sticky, clk_i, rst_ni, phase_q == fcpb_pkg::PH_DONE, phase_q == fcpb_pkg::PH_DONE, "drain left the finished phase")

endmodule

/* sim/tb_fem_csc_pattern_builder_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_fem_csc_pattern_builder_top
// Self-checking bench for the sparsity pattern builder. A short table of
// directed requests is followed by six phases of random requests, each with
// its own dof_count; each pair of phases shares a mix of sender gaps and
// receiver stalls. Every drained word is compared field by field with an
// in-bench model of the node map, the DOF bitmap and the column drain.
// ---------------------------------------------------------------------------
module tb_fem_csc_pattern_builder_top;

  // Field widths taken over from the package.
  localparam int NODE_W        = fcpb_pkg::NODE_W;
  localparam int FI_W          = fcpb_pkg::FI_W;
  localparam int CNT_W         = fcpb_pkg::CNT_W;
  localparam int WORD_W        = fcpb_pkg::WORD_W;
  localparam int MAX_CORNERS   = fcpb_pkg::MAX_CORNERS;
  localparam int DOFS_PER_NODE = fcpb_pkg::DOFS_PER_NODE;

  // Request code that the block ignores; not part of the package enum.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int DOF_LIMIT     = 3 * fcpb_pkg::MAX_FREE_NODES_DEF;
  localparam int PHASE_COUNT   = 6;
  localparam int PHASE_ITEMS   = 325;
  localparam int SETTLE_CYCLES = 64;      // longer than one element request
  localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
  localparam int LIMIT_CYCLES  = 2000000;

  typedef struct packed {
    logic [1:0]                          kind;
    logic [NODE_W-1:0]                   node;
    logic [FI_W-1:0]                     fi;
    logic [MAX_CORNERS-1:0][NODE_W-1:0]  corners;  // [0] is corner a
  } pb_request_t;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] index;
    logic [WORD_W-1:0] value;
    logic              last;
  } pattern_word_t;

  typedef struct packed {
    pb_request_t   req;
    logic          typed;   // the expected word is written in the row itself
    pattern_word_t word;
  } stim_row_t;

  // DUT inputs, all at known values from time zero.
  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata_i  = '0;
  logic              in_valid_i   = 1'b0;
  logic [1:0]        req_type_i   = '0;
  logic [NODE_W-1:0] node_id_i    = '0;
  logic [FI_W-1:0]   free_index_i = '0;
  logic [NODE_W-1:0] corner_a_i   = '0;
  logic [NODE_W-1:0] corner_b_i   = '0;
  logic [NODE_W-1:0] corner_c_i   = '0;
  logic [NODE_W-1:0] corner_d_i   = '0;
  logic [NODE_W-1:0] corner_e_i   = '0;
  logic [NODE_W-1:0] corner_f_i   = '0;
  logic [NODE_W-1:0] corner_g_i   = '0;
  logic [NODE_W-1:0] corner_h_i   = '0;
  logic              out_stall_i  = 1'b0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic              word_kind_o;
  logic [WORD_W-1:0] word_index_o;
  logic [WORD_W-1:0] word_value_o;
  logic              last_word_o;

  fem_csc_pattern_builder_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .node_id_i    (node_id_i),
    .free_index_i (free_index_i),
    .corner_a_i   (corner_a_i),
    .corner_b_i   (corner_b_i),
    .corner_c_i   (corner_c_i),
    .corner_d_i   (corner_d_i),
    .corner_e_i   (corner_e_i),
    .corner_f_i   (corner_f_i),
    .corner_g_i   (corner_g_i),
    .corner_h_i   (corner_h_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_kind_o  (word_kind_o),
    .word_index_o (word_index_o),
    .word_value_o (word_value_o),
    .last_word_o  (last_word_o)
  );

  always #5 clk_i = ~clk_i;

  // -------------------------------------------------------------------------
  // Model of the block. It is advanced only by the driver, at the clock edge
  // at which a request is accepted, so its state always matches the order in
  // which the block saw the requests.
  // -------------------------------------------------------------------------
  logic [FI_W-1:0]      node_free_idx [fcpb_pkg::MAX_NODES_DEF];
  logic [DOF_LIMIT-1:0] dof_pattern   [DOF_LIMIT];   // [column][row]
  logic [CNT_W-1:0]     dof_setting;
  logic [CNT_W-1:0]     col_ptr;
  logic [CNT_W-1:0]     row_ptr;
  logic [WORD_W-1:0]    nz_total;
  fcpb_pkg::phase_e     drain_state;

  pattern_word_t expected_words [$];

  // Bookkeeping.
  int accepted_count  = 0;
  int directed_count  = 0;
  int words_checked   = 0;
  int mismatch_count  = 0;
  int setting_count   = 0;
  int cycle_count     = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int hold_requests   = 0;   // written by the driver only
  int hold_seen       = 0;   // written by the stall process only
  int hold_left       = 0;

  function automatic int eff_dofs();
    return (int'(dof_setting) > DOF_LIMIT) ? DOF_LIMIT : int'(dof_setting);
  endfunction

  // Every pair of the element's free DOFs becomes a nonzero. Corner 0 is
  // absent, a node with free index 0 is fixed, and a DOF past the bitmap is
  // dropped.
  function automatic void mark_element(input pb_request_t r);
    int dof_list [3*MAX_CORNERS];
    int n;
    int fi;
    int dof;
    n = 0;
    for (int k = 0; k < fcpb_pkg::NODES_PER_ELEMENT_DEF; k++) begin
      if (r.corners[k] == '0) continue;
      fi = int'(node_free_idx[r.corners[k]]);
      if (fi == 0) continue;
      for (int d = 0; d < DOFS_PER_NODE; d++) begin
        dof = DOFS_PER_NODE * fi - DOFS_PER_NODE + d;
        if (dof < DOF_LIMIT) begin
          dof_list[n] = dof;
          n++;
        end
      end
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        dof_pattern[dof_list[j]][dof_list[i]] = 1'b1;
  endfunction

  // Start pointer of the current column, or the closing word holding the
  // total nonzero count once the column reaches dof_count.
  function automatic pattern_word_t column_pointer();
    pattern_word_t w;
    w.kind  = fcpb_pkg::KIND_PTR;
    w.index = WORD_W'(col_ptr);
    w.value = nz_total;
    if (int'(col_ptr) < eff_dofs()) begin
      w.last      = 1'b0;
      drain_state = fcpb_pkg::PH_ROW;
      row_ptr     = '0;
    end else begin
      w.last      = 1'b1;
      drain_state = fcpb_pkg::PH_DONE;
    end
    return w;
  endfunction

  // One drain request: the next row of the current column, or else the
  // pointer of the following column. Nothing once the drain has closed.
  function automatic bit next_word(output pattern_word_t w);
    int cnt;
    cnt = eff_dofs();
    w   = '0;
    case (drain_state)
      fcpb_pkg::PH_PTR: begin
        w = column_pointer();
        return 1'b1;
      end
      fcpb_pkg::PH_ROW: begin
        if (int'(col_ptr) < cnt) begin
          for (int r = int'(row_ptr); r < cnt; r++) begin
            if (dof_pattern[col_ptr][r]) begin
              w.kind   = fcpb_pkg::KIND_ROW;
              w.index  = nz_total;
              w.value  = WORD_W'(r);
              w.last   = 1'b0;
              nz_total = nz_total + 1'b1;
              row_ptr  = (r + 1 > 255) ? 8'hFF : CNT_W'(r + 1);
              return 1'b1;
            end
          end
          col_ptr = col_ptr + 1'b1;
        end
        w = column_pointer();
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // True when the next drain request would produce the closing word. The
  // random phases steer around this so that the single drain of the run
  // stays open until the end.
  function automatic bit drain_would_close();
    int cnt;
    int col;
    cnt = eff_dofs();
    col = int'(col_ptr);
    if (drain_state == fcpb_pkg::PH_DONE) return 1'b1;
    if (drain_state == fcpb_pkg::PH_ROW) begin
      if (col >= cnt) return 1'b1;
      for (int r = int'(row_ptr); r < cnt; r++)
        if (dof_pattern[col][r]) return 1'b0;
      col = col + 1;
    end
    return col >= cnt;
  endfunction

  function automatic void apply_request(input pb_request_t r, output bit got,
                                        output pattern_word_t w);
    got = 1'b0;
    w   = '0;
    case (r.kind)
      fcpb_pkg::REQ_LOAD:  node_free_idx[r.node] = r.fi;
      fcpb_pkg::REQ_ELEM:  mark_element(r);
      fcpb_pkg::REQ_DRAIN: got = next_word(w);
      default:   ;
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Request builders for the directed table and the random phases.
  // -------------------------------------------------------------------------
  function automatic pb_request_t load_req(input logic [NODE_W-1:0] node,
                                           input logic [FI_W-1:0] fi);
    pb_request_t r;
    r      = '0;
    r.kind = fcpb_pkg::REQ_LOAD;
    r.node = node;
    r.fi   = fi;
    return r;
  endfunction

  function automatic pb_request_t elem_req(input logic [NODE_W-1:0] a, b, c, d,
                                           input logic [NODE_W-1:0] e, f, g, h);
    pb_request_t r;
    r         = '0;
    r.kind    = fcpb_pkg::REQ_ELEM;
    r.corners = {h, g, f, e, d, c, b, a};
    return r;
  endfunction

  function automatic pb_request_t drain_req();
    pb_request_t r;
    r      = '0;
    r.kind = fcpb_pkg::REQ_DRAIN;
    return r;
  endfunction

  function automatic stim_row_t plain_row(input pb_request_t r);
    stim_row_t s;
    s     = '0;
    s.req = r;
    return s;
  endfunction

  function automatic stim_row_t typed_drain(input logic kind,
                                            input logic [WORD_W-1:0] index, value,
                                            input logic last);
    stim_row_t s;
    s       = '0;
    s.req   = drain_req();
    s.typed = 1'b1;
    s.word  = '{kind: kind, index: index, value: value, last: last};
    return s;
  endfunction

  // Most nodes come from a small pool so that loads and elements meet; the
  // rest spread over the whole node range.
  function automatic logic [NODE_W-1:0] pick_node();
    return ($urandom_range(99) < 85) ? NODE_W'($urandom_range(1, 40))
                                     : NODE_W'($urandom_range(1, 255));
  endfunction

  function automatic pb_request_t random_request();
    pb_request_t r;
    int sel;
    sel = $urandom_range(99);
    r   = '0;
    if (sel < 45) begin
      r = drain_req();
    end else if (sel < 62) begin
      r = load_req(($urandom_range(99) < 70) ? NODE_W'($urandom_range(1, 40))
                                             : NODE_W'($urandom_range(0, 255)),
                   '0);
      case ($urandom_range(19))
        0, 1, 2:    r.fi = '0;
        3, 4, 5:    r.fi = FI_W'($urandom_range(65, 127));  // past the bitmap
        default:    r.fi = FI_W'($urandom_range(1, 64));
      endcase
    end else if (sel < 88) begin
      r.kind = fcpb_pkg::REQ_ELEM;
      for (int k = 0; k < MAX_CORNERS; k++)
        r.corners[k] = ($urandom_range(2) == 0) ? '0 : pick_node();
    end else if (sel < 94) begin
      // Noise element: arbitrary corner numbers, any of which may be zero.
      r.kind = fcpb_pkg::REQ_ELEM;
      for (int k = 0; k < MAX_CORNERS; k++)
        r.corners[k] = NODE_W'($urandom_range(0, 255));
    end else begin
      r.kind    = REQ_UNUSED;
      r.node    = NODE_W'($urandom);
      r.fi      = FI_W'($urandom);
      r.corners = {$urandom, $urandom};
    end
    // Payload fields that a drain request does not use sometimes toggle.
    if (r.kind == fcpb_pkg::REQ_DRAIN && $urandom_range(3) == 0) begin
      r.node    = NODE_W'($urandom);
      r.fi      = FI_W'($urandom);
      r.corners = {$urandom, $urandom};
    end
    if (r.kind == fcpb_pkg::REQ_DRAIN && drain_would_close())
      r = load_req(pick_node(), FI_W'($urandom_range(1, 64)));
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Driver tasks. Inputs change only right after a rising edge, through
  // nonblocking assignments, so the block never samples a value at the edge that set it.
  // -------------------------------------------------------------------------
  task automatic issue(input pb_request_t r, input bit typed,
                       input pattern_word_t typed_word);
    bit got;
    pattern_word_t w;
    in_valid_i   <= 1'b1;
    req_type_i   <= r.kind;
    node_id_i    <= r.node;
    free_index_i <= r.fi;
    corner_a_i   <= r.corners[0];
    corner_b_i   <= r.corners[1];
    corner_c_i   <= r.corners[2];
    corner_d_i   <= r.corners[3];
    corner_e_i   <= r.corners[4];
    corner_f_i   <= r.corners[5];
    corner_g_i   <= r.corners[6];
    corner_h_i   <= r.corners[7];
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    accepted_count++;
    apply_request(r, got, w);
    if (got) expected_words.push_back(typed ? typed_word : w);
    // Sender gaps: valid drops for a run of random length.
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Hold back requests until every expected word is out, then let the last
  // element request finish inside the block.
  task automatic idle_until_drained();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dofs(input logic [CNT_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    dof_setting = v;
    setting_count++;
  endtask

  // -------------------------------------------------------------------------
  // Receiver stalls: random per cycle, or a long hold-off when the driver
  // asks for one. The hold-off is counted down here, so the driver keeps
  // offering requests while the block backs up.
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // -------------------------------------------------------------------------
  // Result checker: each accepted word against the oldest expectation.
  // -------------------------------------------------------------------------
  pattern_word_t seen_word;
  pattern_word_t want_word;

  task automatic report_mismatch(input string what, input pattern_word_t got_w,
                                 input pattern_word_t want);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: got kind %0d index %0d value %0d last %0d, %s %0d %s %0d %s %0d %s %0d",
               $realtime, what, got_w.kind, got_w.index, got_w.value, got_w.last,
               "expected kind", want.kind, "index", want.index,
               "value", want.value, "last", want.last);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      seen_word = {word_kind_o, word_index_o, word_value_o, last_word_o};
      if (expected_words.size() == 0) begin
        report_mismatch("word with no request waiting", seen_word, '0);
      end else begin
        want_word = expected_words.pop_front();
        words_checked++;
        if (seen_word.kind !== want_word.kind || seen_word.index !== want_word.index ||
            seen_word.value !== want_word.value || seen_word.last !== want_word.last)
          report_mismatch("pattern word mismatch", seen_word, want_word);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_words.size());
      $display("FAILURE");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus.
  // -------------------------------------------------------------------------
  stim_row_t directed_rows [$];

  initial begin
    pb_request_t r;
    int counted;
    for (int n = 0; n < fcpb_pkg::MAX_NODES_DEF; n++) node_free_idx[n] = '0;
    for (int c = 0; c < DOF_LIMIT; c++) dof_pattern[c] = '0;
    dof_setting = '0;
    col_ptr     = '0;
    row_ptr     = '0;
    nz_total    = '0;
    drain_state = fcpb_pkg::PH_PTR;

    // Directed table. Node 1 maps to DOFs 0..2, node 128 to 3..5 and node
    // 255 to the last three DOFs of the bitmap; node 2 lies past the bitmap
    // and node 3 is fixed.
    r         = '1;
    r.kind    = REQ_UNUSED;
    directed_rows.push_back(plain_row(r));                   // ignored request
    directed_rows.push_back(plain_row(load_req(8'd0, 7'd127)));
    directed_rows.push_back(plain_row(load_req(8'd255, 7'd64)));
    directed_rows.push_back(plain_row(load_req(8'd1, 7'd1)));
    directed_rows.push_back(plain_row(load_req(8'd2, 7'd65)));
    directed_rows.push_back(plain_row(load_req(8'd3, 7'd0)));
    directed_rows.push_back(plain_row(load_req(8'd128, 7'd2)));
    directed_rows.push_back(plain_row(elem_req(8'd1, 8'd255, 8'd2, 8'd3,
                                               8'd0, 8'd0, 8'd0, 8'd0)));
    directed_rows.push_back(plain_row(elem_req('0, '0, '0, '0, '0, '0, '0, '0)));
    directed_rows.push_back(plain_row(elem_req('1, '1, '1, '1, '1, '1, '1, '1)));
    directed_rows.push_back(plain_row(elem_req('0, '0, '0, '0, '0, '0, '0, 8'd128)));
    // First pointer after reset and the first row of column 0.
    directed_rows.push_back(typed_drain(fcpb_pkg::KIND_PTR, 16'd0, 16'd0, 1'b0));
    directed_rows.push_back(typed_drain(fcpb_pkg::KIND_ROW, 16'd0, 16'd0, 1'b0));
    directed_rows.push_back(plain_row(drain_req()));
    // An element arriving in the middle of column 0 adds rows still ahead.
    directed_rows.push_back(plain_row(elem_req(8'd128, 8'd1, '0, '0, '0, '0, '0, '0)));
    for (int k = 0; k < 8; k++) directed_rows.push_back(plain_row(drain_req()));
    directed_rows.push_back(plain_row(load_req(8'd1, 7'd0)));

    // Reset once, then the widest setting, above the bitmap size.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_dofs(8'd255);

    send_idle_pct = 15;
    recv_idle_pct = 60;
    foreach (directed_rows[i]) begin
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].word);
      directed_count++;
    end
    idle_until_drained();

    // Random phases. Each new dof_count lies above the column being drained
    // so that the drain stays open; the first two are the bitmap size and
    // the register maximum.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0:       write_dofs(CNT_W'(DOF_LIMIT));
        1:       write_dofs(8'd255);
        default: write_dofs(CNT_W'($urandom_range(int'(col_ptr) + 1, 255)));
      endcase
      case (ph / 2)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // Long receiver hold-off while requests keep coming.
      if (ph == 0 || ph == 4) hold_requests++;
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        r = random_request();
        counted++;
        issue(r, 1'b0, '0);
      end
      idle_until_drained();
    end

    // Close the drain two columns on, then check that drains after the end
    // give nothing, with dof_count at zero.
    write_dofs(col_ptr + 8'd2);
    while (drain_state != fcpb_pkg::PH_DONE) issue(drain_req(), 1'b0, '0);
    idle_until_drained();
    write_dofs('0);
    repeat (3) issue(drain_req(), 1'b0, '0);
    idle_until_drained();

    $display("Covered %0d requests (%0d directed) under %0d dof_count settings, %0d %s",
             accepted_count, directed_count, setting_count, words_checked,
             "words checked.");
    $display("Drain closed at column %0d with %0d nonzeros; %0d mismatches.",
             col_ptr, nz_total, mismatch_count);
    if (mismatch_count == 0 && expected_words.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
